/* design/integer_matrix_multiply_top_macros.svh */
// Assertion helpers for the matrix multiply block.
`ifndef INTEGER_MATRIX_MULTIPLY_TOP_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_TOP_MACROS_SVH
`ifndef SYNTH
`define IMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imm assertion failed");
`define IMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imm assertion failed");
`else
`define IMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/imm_pkg.sv */
`default_nettype none
package imm_pkg;

    localparam int IMM_MAX_SIZE = 64;
    localparam int IMM_DATA_W   = 32;
    localparam int IMM_CFG_W    = 7;
    localparam int IMM_IDX_W    = 6;
    localparam logic [IMM_CFG_W-1:0] IMM_SIZE_RST = 7'd64;

    typedef enum logic [1:0] {
        S_LOAD,
        S_MAC,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic                 b_wr;
        logic                 a_wr;
        logic                 mac_vld;
        logic                 mac_first;
        logic                 mac_last;
        logic                 push;
        logic                 row_end;
        logic                 matrix_end;
        logic [IMM_IDX_W-1:0] out_row;
        logic [IMM_IDX_W-1:0] out_col;
    } t_dp_cmd;

    typedef struct packed {
        logic acc_done;
        logic out_busy;
    } t_dp_sts;

endpackage
`default_nettype wire

/* design/imm_intf.sv */
`default_nettype none
interface imm_in_if import imm_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [IMM_DATA_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface imm_out_if import imm_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [IMM_DATA_W-1:0] product;
    logic        [IMM_IDX_W-1:0]  row;
    logic        [IMM_IDX_W-1:0]  column;
    logic                         row_end;
    logic                         matrix_end;

    modport source (output valid, output product, output row, output column,
                    output row_end, output matrix_end, input ready);
    modport sink   (input valid, input product, input row, input column,
                    input row_end, input matrix_end, output ready);
endinterface

interface imm_cfg_if import imm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [IMM_CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/imm_datapath.sv */
`default_nettype none
module imm_datapath import imm_pkg::*; #(
    parameter int MAX_SIZE = IMM_MAX_SIZE
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire t_dp_cmd                             i_cmd,
    output t_dp_sts                                  o_sts,
    input  wire [$clog2(MAX_SIZE*MAX_SIZE)-1:0]      i_b_addr,
    input  wire [$clog2(MAX_SIZE)-1:0]               i_a_addr,
    input  wire [IMM_DATA_W-1:0]                     i_value,
    imm_out_if.source                                o_out
);

    localparam int BDEPTH = MAX_SIZE * MAX_SIZE;

    logic [IMM_DATA_W-1:0] r_b_mem [BDEPTH];
    logic [IMM_DATA_W-1:0] r_a_mem [MAX_SIZE];

    logic [IMM_DATA_W-1:0] r_b_rd;
    logic [IMM_DATA_W-1:0] r_a_rd;
    logic [IMM_DATA_W-1:0] r_prod;
    logic [IMM_DATA_W-1:0] r_acc;
    logic                  r_v1, r_f1, r_l1;
    logic                  r_v2, r_f2, r_l2;
    logic                  r_acc_done;

    logic                  r_out_vld;
    logic [IMM_DATA_W-1:0] r_out_prod;
    logic [IMM_IDX_W-1:0]  r_out_row;
    logic [IMM_IDX_W-1:0]  r_out_col;
    logic                  r_out_rend;
    logic                  r_out_mend;

    always_ff @(posedge i_clk) begin
        if (i_cmd.b_wr) begin
            r_b_mem[i_b_addr] <= i_value;
        end
        if (i_cmd.mac_vld) begin
            r_b_rd <= r_b_mem[i_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.a_wr) begin
            r_a_mem[i_a_addr] <= i_value;
        end
        if (i_cmd.mac_vld) begin
            r_a_rd <= r_a_mem[i_a_addr];
        end
    end

    // read -> multiply -> accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_acc_done <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_vld;
            r_v2 <= r_v1;
            if (r_v2 && r_l2) begin
                r_acc_done <= 1'b1;
            end else if (i_cmd.push) begin
                r_acc_done <= 1'b0;
            end
            if (i_cmd.push) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1   <= i_cmd.mac_first;
        r_l1   <= i_cmd.mac_last;
        r_f2   <= r_f1;
        r_l2   <= r_l1;
        r_prod <= r_a_rd * r_b_rd;
        if (r_v2) begin
            r_acc <= r_f2 ? r_prod : r_acc + r_prod;
        end
        if (i_cmd.push) begin
            r_out_prod <= r_acc;
            r_out_row  <= i_cmd.out_row;
            r_out_col  <= i_cmd.out_col;
            r_out_rend <= i_cmd.row_end;
            r_out_mend <= i_cmd.matrix_end;
        end
    end

    assign o_sts.acc_done  = r_acc_done;
    assign o_sts.out_busy  = r_out_vld && !o_out.ready;

    assign o_out.valid      = r_out_vld;
    assign o_out.product    = r_out_prod;
    assign o_out.row        = r_out_row;
    assign o_out.column     = r_out_col;
    assign o_out.row_end    = r_out_rend;
    assign o_out.matrix_end = r_out_mend;

endmodule
`default_nettype wire

/* design/imm_ctrl.sv */
`default_nettype none
`include "integer_matrix_multiply_top_macros.svh"
module imm_ctrl import imm_pkg::*; #(
    parameter int MAX_SIZE = IMM_MAX_SIZE
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire                                 i_cfg_valid,
    input  wire [IMM_CFG_W-1:0]                 i_cfg_data,
    output logic                                o_cfg_ready,
    input  wire t_dp_sts                        i_sts,
    output t_dp_cmd                             o_cmd,
    output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0] o_b_addr,
    output logic [$clog2(MAX_SIZE)-1:0]         o_a_addr
);

    localparam int IW  = $clog2(MAX_SIZE);
    localparam int NW  = $clog2(MAX_SIZE + 1);
    localparam int SW  = (NW > IMM_CFG_W) ? NW : IMM_CFG_W;
    localparam int BAW = $clog2(MAX_SIZE * MAX_SIZE);

    t_state               r_state, n_state;
    logic [IMM_CFG_W-1:0] r_size, n_size;
    logic                 r_load_a, n_load_a;
    logic [IW-1:0]        r_row, n_row;
    logic [IW-1:0]        r_col, n_col;
    logic [IW-1:0]        r_j, n_j;
    logic [IW-1:0]        r_k, n_k;

    logic [SW-1:0]        w_size_ext;
    logic [NW-1:0]        w_size_act;
    logic [IW-1:0]        w_last;
    logic                 w_in_acc;
    logic                 w_cfg_wr;

    assign w_size_ext = SW'(r_size);

    always_comb begin
        if (r_size == '0) begin
            w_size_act = NW'(1);
        end else if (w_size_ext > SW'(MAX_SIZE)) begin
            w_size_act = NW'(MAX_SIZE);
        end else begin
            w_size_act = NW'(w_size_ext);
        end
    end

    assign w_last      = IW'(w_size_act - NW'(1));
    assign o_in_ready  = (r_state == S_LOAD);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_size   <= IMM_SIZE_RST;
            r_load_a <= 1'b0;
            r_row    <= '0;
            r_col    <= '0;
            r_j      <= '0;
            r_k      <= '0;
        end else begin
            r_state  <= n_state;
            r_size   <= n_size;
            r_load_a <= n_load_a;
            r_row    <= n_row;
            r_col    <= n_col;
            r_j      <= n_j;
            r_k      <= n_k;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_size   = r_size;
        n_load_a = r_load_a;
        n_row    = r_row;
        n_col    = r_col;
        n_j      = r_j;
        n_k      = r_k;
        o_cmd    = '0;
        o_b_addr = BAW'(r_row) * BAW'(MAX_SIZE) + BAW'(r_col);
        o_a_addr = r_col;

        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    o_cmd.b_wr = !r_load_a;
                    o_cmd.a_wr = r_load_a;
                    if (r_col == w_last) begin
                        n_col = '0;
                        if (r_load_a) begin
                            n_state = S_MAC;
                            n_j     = '0;
                            n_k     = '0;
                        end else if (r_row == w_last) begin
                            n_row    = '0;
                            n_load_a = 1'b1;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            S_MAC: begin
                o_b_addr        = BAW'(r_k) * BAW'(MAX_SIZE) + BAW'(r_j);
                o_a_addr        = r_k;
                o_cmd.mac_vld   = 1'b1;
                o_cmd.mac_first = (r_k == '0);
                if (r_k == w_last) begin
                    o_cmd.mac_last = 1'b1;
                    n_k            = '0;
                    n_state        = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                if (i_sts.acc_done && !i_sts.out_busy) begin
                    o_cmd.push       = 1'b1;
                    o_cmd.row_end    = (r_j == w_last);
                    o_cmd.matrix_end = (r_j == w_last) && (r_row == w_last);
                    o_cmd.out_row    = IMM_IDX_W'(r_row);
                    o_cmd.out_col    = IMM_IDX_W'(r_j);
                    if (r_j == w_last) begin
                        n_j     = '0;
                        n_state = S_LOAD;
                        if (r_row == w_last) begin
                            n_row    = '0;
                            n_load_a = 1'b0;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_MAC;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        if (w_cfg_wr) begin
            n_size   = i_cfg_data;
            n_load_a = 1'b0;
            n_row    = '0;
            n_col    = '0;
            n_j      = '0;
            n_k      = '0;
            n_state  = S_LOAD;
        end
    end

    `IMM_ASSERT_IMP(a_push_ok, i_clk, i_rst_n, o_cmd.push, i_sts.acc_done && !i_sts.out_busy)
    `IMM_ASSERT_NXT(a_mac_drain, i_clk, i_rst_n, o_cmd.mac_last && !w_cfg_wr, r_state == S_DRAIN)
    `IMM_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, r_state == S_MAC, r_k <= w_last && r_j <= w_last)
    `IMM_ASSERT_NXT(a_mend_phase, i_clk, i_rst_n, o_cmd.push && o_cmd.matrix_end, !r_load_a)

endmodule
`default_nettype wire

/* design/integer_matrix_multiply_top.sv */
// Streams B then A (one element per cycle while loading, n*n each); C rows out per A row.
// Each result column: n reads/MACs, multiply and add stages, output load.
// The first product of a row follows once the row's last A element is taken.
// Input is held off while a row of C is computed (single MAC unit).
// Reset (i_rst_n low, synchronous): size 64, B phase, counters cleared; stores not cleared.
`default_nettype none
module integer_matrix_multiply_top import imm_pkg::*; #(
    parameter int MAX_SIZE = IMM_MAX_SIZE
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    imm_in_if.sink     i_in,
    imm_cfg_if.sink    i_cfg,
    imm_out_if.source  o_out
);

    localparam int IW  = $clog2(MAX_SIZE);
    localparam int BAW = $clog2(MAX_SIZE * MAX_SIZE);

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic [BAW-1:0]   w_b_addr;
    logic [IW-1:0]    w_a_addr;
    logic             w_in_ready;
    logic             w_cfg_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = w_cfg_ready;

    imm_ctrl #(
        .MAX_SIZE (MAX_SIZE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_cfg_ready (w_cfg_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_b_addr    (w_b_addr),
        .o_a_addr    (w_a_addr)
    );

    imm_datapath #(
        .MAX_SIZE (MAX_SIZE)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_b_addr (w_b_addr),
        .i_a_addr (w_a_addr),
        .i_value  (i_in.value),
        .o_out    (o_out)
    );

endmodule
`default_nettype wire

/* tb/sv/imm_product_checker.sv */
`timescale 1ns / 100ps
module imm_product_checker import imm_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    imm_in_if         i_in,
    imm_cfg_if        i_cfg,
    imm_out_if        i_out,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        logic [IMM_DATA_W-1:0] product;
        logic [IMM_IDX_W-1:0]  row;
        logic [IMM_IDX_W-1:0]  column;
        logic                  row_end;
        logic                  matrix_end;
    } t_product;

    logic [IMM_DATA_W-1:0] b_matrix [IMM_MAX_SIZE*IMM_MAX_SIZE];
    logic [IMM_DATA_W-1:0] a_row    [IMM_MAX_SIZE];
    logic [IMM_CFG_W-1:0]  size_reg;
    int unsigned           position;
    bit                    loading_a;
    t_product              expected_products [$];
    int                    mismatches;

    task automatic report_mismatch(input string field, input logic [IMM_DATA_W-1:0] got,
                                   input logic [IMM_DATA_W-1:0] want);
        mismatches++;
        $display("%0t: %s mismatch at row %0d col %0d: got %0h, want %0h",
                 $time, field, i_out.row, i_out.column, got, want);
    endtask

    task automatic absorb_element(input logic [IMM_DATA_W-1:0] v);
        int unsigned n;
        int unsigned total;
        int unsigned r;
        int unsigned c;
        logic [IMM_DATA_W-1:0] acc;
        t_product item;
        n = (size_reg == '0) ? 1 :
            (size_reg > IMM_MAX_SIZE) ? IMM_MAX_SIZE : int'(size_reg);
        total = n * n;
        if (position >= total) position = 0;
        r = position / n;
        c = position % n;
        if (!loading_a) begin
            b_matrix[r*IMM_MAX_SIZE + c] = v;
            position++;
            if (position >= total) begin
                position = 0;
                loading_a = 1'b1;
            end
        end else begin
            a_row[c] = v;
            position++;
            if (c == n - 1) begin
                for (int unsigned j = 0; j < n; j++) begin
                    acc = '0;
                    for (int unsigned k = 0; k < n; k++) begin
                        acc = acc + a_row[k] * b_matrix[k*IMM_MAX_SIZE + j];
                    end
                    item.product    = acc;
                    item.row        = r[IMM_IDX_W-1:0];
                    item.column     = j[IMM_IDX_W-1:0];
                    item.row_end    = (j == n - 1);
                    item.matrix_end = (r == n - 1) && (j == n - 1);
                    expected_products.push_back(item);
                end
                if (r == n - 1) begin
                    position = 0;
                    loading_a = 1'b0;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_product want;
        if (!i_rst_n) begin
            size_reg = IMM_SIZE_RST;
            position = 0;
            loading_a = 1'b0;
            expected_products.delete();
            mismatches = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (expected_products.size() == 0) begin
                    report_mismatch("unexpected result", i_out.product, '0);
                end else begin
                    want = expected_products.pop_front();
                    if (i_out.product !== want.product)
                        report_mismatch("product", i_out.product, want.product);
                    if (i_out.row !== want.row)
                        report_mismatch("row", 32'(i_out.row), 32'(want.row));
                    if (i_out.column !== want.column)
                        report_mismatch("column", 32'(i_out.column), 32'(want.column));
                    if (i_out.row_end !== want.row_end)
                        report_mismatch("row_end", 32'(i_out.row_end), 32'(want.row_end));
                    if (i_out.matrix_end !== want.matrix_end)
                        report_mismatch("matrix_end", 32'(i_out.matrix_end),
                                        32'(want.matrix_end));
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                size_reg = i_cfg.data;
                position = 0;
                loading_a = 1'b0;
            end
            if (i_in.valid && i_in.ready) begin
                absorb_element(i_in.value);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_products.size();
    end

endmodule

/* tb/sv/tb_integer_matrix_multiply_top.sv */
`timescale 1ns / 100ps
module tb_integer_matrix_multiply_top;
    import imm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 2 * (IMM_MAX_SIZE + 3);

    logic i_clk = 1'b0;
    logic i_rst_n;

    imm_in_if  in_ch ();
    imm_cfg_if cfg_ch ();
    imm_out_if out_ch ();

    int mismatch_count;
    int pending_results;
    int send_idle_pct;
    int recv_idle_pct;
    int sent_count;
    int quiet_cycles;
    bit pressure_done;

    integer_matrix_multiply_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    imm_product_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_cfg        (cfg_ch),
        .i_out        (out_ch),
        .o_fail_count (mismatch_count),
        .o_pending    (pending_results)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [IMM_DATA_W-1:0] pick_value();
        logic [IMM_DATA_W-1:0] val;
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(4))
                    0: val = 32'h8000_0000;
                    1: val = 32'h7fff_ffff;
                    2: val = 32'h0000_0000;
                    3: val = 32'hffff_ffff;
                    default: val = 32'h0000_0001;
                endcase
            end
            1, 2: begin
                val = 32'($urandom_range(15)) - 32'd8;
            end
            default: val = $urandom();
        endcase
        return val;
    endfunction

    // entered and left just after a falling edge
    task automatic send_element(input logic [IMM_DATA_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic write_size(input logic [IMM_CFG_W-1:0] sz);
        in_ch.valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= sz;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic stream_matrices(input int n, input int b_count, input int a_count);
        for (int i = 0; i < b_count; i++) send_element(pick_value());
        for (int i = 0; i < a_count; i++) begin
            send_element(pick_value());
            if ((i % n) == n - 1 && (!pressure_done || $urandom_range(7) == 0)) begin
                pressure_done = 1'b1;
                in_ch.valid <= 1'b0;
                @(negedge i_clk);
                while (pending_results != 0) @(negedge i_clk);
            end
        end
    endtask

    task automatic random_settings(input int count);
        int target;
        int sz;
        int n;
        int products;
        target = sent_count + count;
        while (sent_count < target) begin
            if ($urandom_range(9) == 0) sz = 0;
            else if ($urandom_range(4) == 0) sz = $urandom_range(7, 9);
            else sz = $urandom_range(1, 6);
            write_size(sz[IMM_CFG_W-1:0]);
            n = (sz == 0) ? 1 : sz;
            products = $urandom_range(1, 2);
            for (int p = 0; p < products; p++) begin
                if (p == products - 1 && $urandom_range(4) == 0) begin
                    if ($urandom_range(1) == 0)
                        stream_matrices(n, $urandom_range(1, n * n - 1), 0);
                    else
                        stream_matrices(n, n * n, $urandom_range(1, n * n - 1));
                end else begin
                    stream_matrices(n, n * n, n * n);
                end
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        sent_count   = 0;
        quiet_cycles = 0;
        pressure_done = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 58;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // size out of reset
        stream_matrices(IMM_MAX_SIZE, 8, 0);

        write_size(7'd1);
        send_element(32'h8000_0000);
        send_element(32'h8000_0000);
        send_element(32'h7fff_ffff);
        send_element(32'h7fff_ffff);
        send_element(32'h8000_0000);
        send_element(32'hffff_ffff);

        // zero size acts as one
        write_size(7'd0);
        send_element(32'd7);
        send_element(-32'sd3);

        write_size(7'd2);
        send_element(32'h7fff_ffff);
        send_element(32'h8000_0000);
        send_element(32'hffff_ffff);
        send_element(32'h0000_0001);
        send_element(32'h0000_0001);
        send_element(32'hffff_ffff);
        send_element(32'h8000_0000);
        send_element(32'h7fff_ffff);

        // size change in the middle of B
        write_size(7'd3);
        stream_matrices(3, 3, 0);
        write_size(7'd2);
        stream_matrices(2, 4, 2);

        random_settings(80);

        send_idle_pct = 58;
        recv_idle_pct = 33;
        write_size(7'd64);
        stream_matrices(IMM_MAX_SIZE, 5, 0);
        random_settings(80);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_settings(80);
        // above the maximum acts as the maximum; start of B
        write_size(7'd127);
        stream_matrices(IMM_MAX_SIZE, 8, 0);

        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
